// ----- src/mexp_pkg.sv -----
package mexp_pkg;

    localparam int VALUE_WIDTH = 12;

    // Counter for the bit-serial multiplier; it has to hold VALUE_WIDTH itself.
    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    // Configuration register file.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS          = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PUBLIC_EXPONENT  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_PRIVATE_EXPONENT = CFG_IDX_W'(2);

    localparam logic [VALUE_WIDTH-1:0] MODULUS_RESET  = VALUE_WIDTH'(3721);
    localparam logic [VALUE_WIDTH-1:0] EXPONENT_RESET = VALUE_WIDTH'(1);

    // Input selector codes.
    localparam logic FUNC_ENCRYPT = 1'b0;
    localparam logic FUNC_DECRYPT = 1'b1;

    // Operand pair fed into the modular multiplier.
    typedef enum logic {
        MUL_ACC = 1'b0,   // accumulator times square
        MUL_SQ  = 1'b1    // square times square
    } mul_sel_t;

    typedef struct packed {
        logic     load;       // take a new item and start the base reduction
        logic     mul_start;  // load multiplier operands chosen by mul_sel
        mul_sel_t mul_sel;
        logic     mul_step;   // one multiplier bit
        logic     wr_sq;      // multiplier result into the square register
        logic     wr_acc;     // multiplier result into the accumulator
        logic     exp_shift;  // move to the next exponent bit
        logic     out_load;   // place the final value in the output register
    } mexp_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic exp_bit;
        logic exp_zero;
        logic mod_small;
        logic out_free;
    } mexp_stat_t;

endpackage

// ----- src/mexp_if.sv -----
interface mexp_in_if import mexp_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   func;
    logic [VALUE_WIDTH-1:0] base_value;

    modport source (output valid, output func, output base_value, input ready);
    modport sink (input valid, input func, input base_value, output ready);
endinterface

interface mexp_out_if import mexp_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] power_result;

    modport source (output valid, output power_result, input ready);
    modport sink (input valid, input power_result, output ready);
endinterface

interface mexp_cfg_if import mexp_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [VALUE_WIDTH-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/modular_exponentiation_unit_top.sv -----
// Modular exponentiation unit. Each item on req carries a base value and a
// selector; the block returns base raised to the public exponent (func = 0) or
// the private exponent (func = 1), reduced modulo the configured modulus, as one
// item on rsp. An exponent of zero gives 1, and a modulus below two gives 0.
// The three registers (modulus, public exponent, private exponent at indexes 0,
// 1 and 2) are written through cfg, which is always ready; an index of 3 is
// ignored, and they should only be written while no item is in flight.
// One item is worked on at a time. The work is done by a bit-serial modular
// multiplier that handles one multiplier bit per clock. Each item first has its
// base reduced on the multiplier; then, for each exponent bit up to the highest
// set one, the accumulator is multiplied by the square if the bit is set, and
// the square is squared. A zero exponent goes to the result right after the
// reduction, and a modulus below two skips the arithmetic. A finished result
// sits in an output register, so the next item is taken while the previous one
// still waits for rsp.ready.
module modular_exponentiation_unit_top import mexp_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    mexp_in_if.sink     req,
    mexp_out_if.source  rsp,
    mexp_cfg_if.sink    cfg
);

    mexp_cmd_t  cmd;
    mexp_stat_t stat;
    logic       in_ready;

    // The controller owns the input handshake; the datapath owns the
    // configuration registers and the output register.
    assign req.ready = in_ready;

    mexp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mexp_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .func       (req.func),
        .base_value (req.base_value),
        .cfg        (cfg),
        .rsp        (rsp)
    );

`ifndef SYNTHESIS
    // A finished result is never written over one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!rsp.valid || rsp.ready))
        else $error("output register overwritten while a result was pending");

    // Every loaded result shows up on rsp in the next cycle.
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> rsp.valid)
        else $error("loaded result not presented");

    // The multiplier is never stepped past its last bit.
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_step |-> !stat.mul_done)
        else $error("multiplier stepped after completion");

    // Only one item is in work at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("second item accepted while busy");
`endif

endmodule

// ----- src/mexp_dp.sv -----
module mexp_dp import mexp_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mexp_cmd_t              cmd,
    output mexp_stat_t             stat,
    input  logic                   func,
    input  logic [VALUE_WIDTH-1:0] base_value,
    mexp_cfg_if.sink               cfg,
    mexp_out_if.source             rsp
);

    logic [VALUE_WIDTH-1:0] modulus_reg;
    logic [VALUE_WIDTH-1:0] pub_exp_reg;
    logic [VALUE_WIDTH-1:0] priv_exp_reg;

    logic [VALUE_WIDTH-1:0] acc_reg;
    logic [VALUE_WIDTH-1:0] sq_reg;
    logic [VALUE_WIDTH-1:0] exp_reg;
    logic [VALUE_WIDTH-1:0] mul_a_reg;
    logic [VALUE_WIDTH-1:0] mul_b_reg;
    logic [VALUE_WIDTH-1:0] mul_r_reg;
    logic [CNT_W-1:0]       mul_cnt_reg;
    logic [CNT_W-1:0]       mul_cnt_next;
    logic [VALUE_WIDTH-1:0] res_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;

    logic [VALUE_WIDTH+1:0] sum;
    logic [VALUE_WIDTH+1:0] mod_x1;
    logic [VALUE_WIDTH+1:0] mod_x2;
    logic [VALUE_WIDTH+1:0] sub_x1;
    logic [VALUE_WIDTH+1:0] sub_x2;
    logic [VALUE_WIDTH-1:0] mul_r_next;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= MODULUS_RESET;
            pub_exp_reg  <= EXPONENT_RESET;
            priv_exp_reg <= EXPONENT_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_MODULUS:          modulus_reg  <= cfg.data;
                REG_PUBLIC_EXPONENT:  pub_exp_reg  <= cfg.data;
                REG_PRIVATE_EXPONENT: priv_exp_reg <= cfg.data;
                default:              ;
            endcase
        end
    end

    // One step of interleaved modular multiplication: r = 2r + bit*a, then
    // bring it back below the modulus. With r and a below m the sum is below 3m.
    assign sum    = {1'b0, mul_r_reg, 1'b0}
                  + {2'b00, (mul_b_reg[VALUE_WIDTH-1] ? mul_a_reg : {VALUE_WIDTH{1'b0}})};
    assign mod_x1 = {2'b00, modulus_reg};
    assign mod_x2 = {1'b0, modulus_reg, 1'b0};
    assign sub_x1 = sum - mod_x1;
    assign sub_x2 = sum - mod_x2;

    always_comb
    begin
        if (sum >= mod_x2)
        begin
            mul_r_next = sub_x2[VALUE_WIDTH-1:0];
        end
        else if (sum >= mod_x1)
        begin
            mul_r_next = sub_x1[VALUE_WIDTH-1:0];
        end
        else
        begin
            mul_r_next = sum[VALUE_WIDTH-1:0];
        end
    end

    always_comb
    begin
        mul_cnt_next = mul_cnt_reg;
        if (cmd.load || cmd.mul_start)
        begin
            mul_cnt_next = CNT_W'(VALUE_WIDTH);
        end
        else if (cmd.mul_step)
        begin
            mul_cnt_next = mul_cnt_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mul_cnt_reg   <= mul_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            // The base is first reduced as 1 * base mod m on the same unit.
            mul_a_reg <= VALUE_WIDTH'(1);
            mul_b_reg <= base_value;
            mul_r_reg <= '0;
            acc_reg   <= VALUE_WIDTH'(1);
            exp_reg   <= (func == FUNC_DECRYPT) ? priv_exp_reg : pub_exp_reg;
        end
        else
        begin
            if (cmd.mul_start)
            begin
                mul_a_reg <= (cmd.mul_sel == MUL_ACC) ? acc_reg : sq_reg;
                mul_b_reg <= sq_reg;
                mul_r_reg <= '0;
            end
            else if (cmd.mul_step)
            begin
                mul_b_reg <= {mul_b_reg[VALUE_WIDTH-2:0], 1'b0};
                mul_r_reg <= mul_r_next;
            end
            if (cmd.wr_acc)
            begin
                acc_reg <= mul_r_reg;
            end
            if (cmd.exp_shift)
            begin
                exp_reg <= {1'b0, exp_reg[VALUE_WIDTH-1:1]};
            end
        end
        if (cmd.wr_sq)
        begin
            sq_reg <= mul_r_reg;
        end
        if (cmd.out_load)
        begin
            res_reg <= stat.mod_small ? '0 : acc_reg;
        end
    end

    assign stat.mul_done  = (mul_cnt_reg == '0);
    assign stat.exp_bit   = exp_reg[0];
    assign stat.exp_zero  = (exp_reg == '0);
    assign stat.mod_small = (modulus_reg < VALUE_WIDTH'(2));
    assign stat.out_free  = !out_valid_reg || rsp.ready;

    assign rsp.valid        = out_valid_reg;
    assign rsp.power_result = res_reg;

endmodule

// ----- src/mexp_ctrl.sv -----
module mexp_ctrl import mexp_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  mexp_stat_t stat,
    output mexp_cmd_t  cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_REDUCE = 6'b000010,
        ST_BIT    = 6'b000100,
        ST_ACC    = 6'b001000,
        ST_SQ     = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.mod_small ? ST_FINISH : ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (!stat.mul_done)
                begin
                    cmd.mul_step = 1'b1;
                end
                else
                begin
                    cmd.wr_sq  = 1'b1;
                    state_next = ST_BIT;
                end
            end
            ST_BIT:
            begin
                if (stat.exp_zero)
                begin
                    state_next = ST_FINISH;
                end
                else if (stat.exp_bit)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MUL_ACC;
                    state_next    = ST_ACC;
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MUL_SQ;
                    state_next    = ST_SQ;
                end
            end
            ST_ACC:
            begin
                if (!stat.mul_done)
                begin
                    cmd.mul_step = 1'b1;
                end
                else
                begin
                    cmd.wr_acc    = 1'b1;
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MUL_SQ;
                    state_next    = ST_SQ;
                end
            end
            ST_SQ:
            begin
                if (!stat.mul_done)
                begin
                    cmd.mul_step = 1'b1;
                end
                else
                begin
                    cmd.wr_sq     = 1'b1;
                    cmd.exp_shift = 1'b1;
                    state_next    = ST_BIT;
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- tb/sv/modular_exponentiation_unit_top_test.sv -----
module modular_exponentiation_unit_top_test;
    import mexp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Index 3 is decoded by the block but maps to no register.
    localparam logic [CFG_IDX_W-1:0] REG_NONE = CFG_IDX_W'(3);

    // The watchdog limit is several times the longest of the slowest item's
    // arithmetic, a sender gap, a receiver stall and the long output stall.
    localparam int LONG_HOLD      = 600;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int END_CYCLES     = 350;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_ITEMS    = 68;

    // One expected result, together with the item that caused it so that a
    // mismatch can be traced back.
    typedef struct {
        logic                   func;
        logic [VALUE_WIDTH-1:0] base_value;
        logic [VALUE_WIDTH-1:0] power_result;
    } power_expect_t;

    logic clk;
    logic rst_n;

    mexp_in_if  req_if ();
    mexp_out_if rsp_if ();
    mexp_cfg_if cfg_if ();

    modular_exponentiation_unit_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    // The testbench's own copy of the three registers, updated whenever a write
    // is accepted on the configuration channel.
    logic [VALUE_WIDTH-1:0] cur_modulus;
    logic [VALUE_WIDTH-1:0] cur_public_exp;
    logic [VALUE_WIDTH-1:0] cur_private_exp;

    // Results the block still owes, oldest first.
    power_expect_t expected_powers[$];

    // Idling controls. When a flag is clear that side never waits, which gives
    // stretches of back-to-back traffic.
    bit send_idle;
    bit recv_idle;
    bit hold_request;

    // Cycles the sender waits before offering its next item. Zero means the
    // valid line is still high from the previous item.
    int lead_gap;

    int items_sent;
    int results_checked;
    int settings_applied;
    int long_holds;
    int mismatches;
    int quiet_cycles;

    always #2 clk = ~clk;

    // Base to the power of the exponent, modulo the modulus, by square and
    // multiply over every exponent bit. The products of two reduced values fit
    // in twice the value width. A modulus of 0 or 1 yields 0.
    function automatic logic [VALUE_WIDTH-1:0] power_mod(
        input logic [VALUE_WIDTH-1:0] base_value,
        input logic [VALUE_WIDTH-1:0] exponent,
        input logic [VALUE_WIDTH-1:0] modulus
    );
        logic [2*VALUE_WIDTH-1:0] acc;
        logic [2*VALUE_WIDTH-1:0] square;
        logic [2*VALUE_WIDTH-1:0] wide_mod;

        if (modulus < VALUE_WIDTH'(2))
            return '0;
        wide_mod = {{VALUE_WIDTH{1'b0}}, modulus};
        acc      = (2*VALUE_WIDTH)'(1);
        square   = {{VALUE_WIDTH{1'b0}}, base_value} % wide_mod;
        for (int i = 0; i < VALUE_WIDTH; i++)
        begin
            if (exponent[i])
                acc = (acc * square) % wide_mod;
            square = (square * square) % wide_mod;
        end
        return acc[VALUE_WIDTH-1:0];
    endfunction

    function automatic int draw_gap(input bit enabled);
        return enabled ? $urandom_range(0, 19) : 0;
    endfunction

    // Extremes turn up often; the rest of the time any legal modulus, and now
    // and then a modulus of 0 or 1, which the block answers with 0.
    function automatic logic [VALUE_WIDTH-1:0] pick_modulus();
        case ($urandom_range(0, 9))
            0:       return VALUE_WIDTH'(2);
            1:       return '1;
            2:       return VALUE_WIDTH'($urandom_range(0, 1));
            3:       return VALUE_WIDTH'(3233);
            default: return VALUE_WIDTH'($urandom_range(2, 4095));
        endcase
    endfunction

    function automatic logic [VALUE_WIDTH-1:0] pick_exponent();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return VALUE_WIDTH'($urandom_range(1, 15));
            default: return VALUE_WIDTH'($urandom);
        endcase
    endfunction

    // Offers one item, waits for the block to take it and queues the expected
    // power. It returns at the falling edge after acceptance, having already
    // decided whether the next item follows at once or after a gap, so the
    // valid line is never dropped and raised within one time step.
    task automatic send_item(input logic func, input logic [VALUE_WIDTH-1:0] base_value);
        power_expect_t entry;
        logic [VALUE_WIDTH-1:0] exponent;

        repeat (lead_gap) @(negedge clk);
        req_if.valid      <= 1'b1;
        req_if.func       <= func;
        req_if.base_value <= base_value;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        exponent            = (func == FUNC_DECRYPT) ? cur_private_exp : cur_public_exp;
        entry.func          = func;
        entry.base_value    = base_value;
        entry.power_result  = power_mod(base_value, exponent, cur_modulus);
        expected_powers.push_back(entry);
        items_sent++;
        @(negedge clk);
        lead_gap = draw_gap(send_idle);
        if (lead_gap != 0)
            req_if.valid <= 1'b0;
    endtask

    // Stops offering items and waits until every expected result has come
    // back. Each item yields a result, so the block is idle once the queue is
    // empty; the few extra cycles are only a margin.
    task automatic wait_idle();
        if (lead_gap == 0)
            req_if.valid <= 1'b0;
        while (expected_powers.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(
        input logic [CFG_IDX_W-1:0]   index,
        input logic [VALUE_WIDTH-1:0] data
    );
        cfg_if.valid <= 1'b1;
        cfg_if.index <= index;
        cfg_if.data  <= data;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        case (index)
            REG_MODULUS:          cur_modulus     = data;
            REG_PUBLIC_EXPONENT:  cur_public_exp  = data;
            REG_PRIVATE_EXPONENT: cur_private_exp = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_if.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apply_settings(
        input logic [VALUE_WIDTH-1:0] modulus,
        input logic [VALUE_WIDTH-1:0] public_exp,
        input logic [VALUE_WIDTH-1:0] private_exp
    );
        wait_idle();
        write_register(REG_MODULUS, modulus);
        write_register(REG_PUBLIC_EXPONENT, public_exp);
        write_register(REG_PRIVATE_EXPONENT, private_exp);
        settings_applied++;
    endtask

    // Registers as they come out of reset: modulus 3721 and both exponents 1,
    // so every item returns its base reduced by the modulus.
    task automatic test_reset_values();
        send_item(FUNC_ENCRYPT, VALUE_WIDTH'(0));
        send_item(FUNC_DECRYPT, VALUE_WIDTH'(4095));
        send_item(FUNC_ENCRYPT, VALUE_WIDTH'(3721));
        send_item(FUNC_DECRYPT, VALUE_WIDTH'(3720));
    endtask

    // Largest and smallest modulus against full and zero exponents. Zero to
    // the power zero must still give 1.
    task automatic test_exponent_extremes();
        apply_settings(VALUE_WIDTH'(4095), VALUE_WIDTH'(4095), VALUE_WIDTH'(0));
        send_item(FUNC_ENCRYPT, VALUE_WIDTH'(0));
        send_item(FUNC_ENCRYPT, VALUE_WIDTH'(4095));
        send_item(FUNC_ENCRYPT, VALUE_WIDTH'(2));
        send_item(FUNC_DECRYPT, VALUE_WIDTH'(0));
        send_item(FUNC_DECRYPT, VALUE_WIDTH'(4095));
        apply_settings(VALUE_WIDTH'(2), VALUE_WIDTH'(2048), VALUE_WIDTH'(4095));
        send_item(FUNC_ENCRYPT, VALUE_WIDTH'(4095));
        send_item(FUNC_DECRYPT, VALUE_WIDTH'(4094));
        send_item(FUNC_DECRYPT, VALUE_WIDTH'(1));
    endtask

    // A modulus of 0 or 1 is outside the intended range; the block answers 0
    // whatever the base and exponent, even for a zero exponent.
    task automatic test_small_modulus();
        apply_settings(VALUE_WIDTH'(0), VALUE_WIDTH'(5), VALUE_WIDTH'(0));
        send_item(FUNC_ENCRYPT, VALUE_WIDTH'(7));
        send_item(FUNC_DECRYPT, VALUE_WIDTH'(4095));
        apply_settings(VALUE_WIDTH'(1), VALUE_WIDTH'(4095), VALUE_WIDTH'(0));
        send_item(FUNC_ENCRYPT, VALUE_WIDTH'(0));
        send_item(FUNC_DECRYPT, VALUE_WIDTH'(9));
    endtask

    // A write to the unused index must leave all three registers alone. The
    // key pair is a classic small one, so decrypting the ciphertext of 65
    // gives 65 back.
    task automatic test_ignored_index();
        apply_settings(VALUE_WIDTH'(3233), VALUE_WIDTH'(17), VALUE_WIDTH'(2753));
        write_register(REG_NONE, VALUE_WIDTH'($urandom));
        send_item(FUNC_ENCRYPT, VALUE_WIDTH'(65));
        send_item(FUNC_DECRYPT, VALUE_WIDTH'(2790));
    endtask

    // The receiver holds off for a long stretch after its next result while
    // the sender keeps offering items with no gaps. Short exponents keep the
    // arithmetic quick, so the output register and the working item fill up
    // and the input has to stall.
    task automatic test_output_stall();
        apply_settings(VALUE_WIDTH'($urandom_range(2, 4095)), VALUE_WIDTH'(3), VALUE_WIDTH'(5));
        send_idle    = 1'b0;
        recv_idle    = 1'b0;
        hold_request = 1'b1;
        repeat (12)
            send_item($urandom_range(0, 1) ? FUNC_DECRYPT : FUNC_ENCRYPT,
                      VALUE_WIDTH'($urandom));
    endtask

    // Random sessions: each phase picks new register values while the block is
    // idle, then sends a batch of random items under its own idling pattern.
    // Bases lean toward zero, all ones and values at the modulus so that the
    // reduction of the base is exercised.
    task automatic test_random_sessions();
        logic [VALUE_WIDTH-1:0] base_value;

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            apply_settings(pick_modulus(), pick_exponent(), pick_exponent());
            if ($urandom_range(0, 3) == 0)
                write_register(REG_NONE, VALUE_WIDTH'($urandom));
            send_idle = ($urandom_range(0, 2) != 0);
            recv_idle = ($urandom_range(0, 2) != 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                case ($urandom_range(0, 9))
                    0:       base_value = '0;
                    1:       base_value = '1;
                    2:       base_value = cur_modulus;
                    3:       base_value = cur_modulus - 1'b1;
                    default: base_value = VALUE_WIDTH'($urandom);
                endcase
                send_item($urandom_range(0, 1) ? FUNC_DECRYPT : FUNC_ENCRYPT, base_value);
            end
        end
    endtask

    // Stimulus. Every input is driven to a known value at time zero, reset is
    // held and then released at a falling edge, and the tests run in turn.
    initial
    begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        req_if.valid      = 1'b0;
        req_if.func       = FUNC_ENCRYPT;
        req_if.base_value = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = REG_MODULUS;
        cfg_if.data       = '0;
        cur_modulus       = MODULUS_RESET;
        cur_public_exp    = EXPONENT_RESET;
        cur_private_exp   = EXPONENT_RESET;
        send_idle         = 1'b1;
        recv_idle         = 1'b1;
        hold_request      = 1'b0;
        lead_gap          = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_values();
        test_exponent_extremes();
        test_small_modulus();
        test_ignored_index();
        test_output_stall();
        test_random_sessions();

        wait_idle();
        repeat (END_CYCLES) @(negedge clk);

        $display("Covered %0d items under %0d register settings, with both selectors,",
                 items_sent, settings_applied);
        $display("zero and full exponents, moduli 0 to 4095, %0d long output stall(s), %0d results.",
                 long_holds, results_checked);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side. For every result the receiver draws its own stall, or takes
    // the long hold when one has been requested, then takes the next item and
    // compares it with the oldest expectation.
    initial
    begin : power_checker
        int            stall_cycles;
        power_expect_t entry;

        rsp_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_cycles = LONG_HOLD;
                long_holds++;
            end
            else
                stall_cycles = draw_gap(recv_idle);
            if (stall_cycles != 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (stall_cycles) @(negedge clk);
            end
            rsp_if.ready <= 1'b1;
            @(posedge clk);
            while (!(rsp_if.valid && rsp_if.ready))
                @(posedge clk);
            if (expected_powers.size() == 0)
            begin
                $error("power_result arrived with nothing expected: actual %0d",
                       rsp_if.power_result);
                mismatches++;
            end
            else
            begin
                entry = expected_powers.pop_front();
                results_checked++;
                if (rsp_if.power_result !== entry.power_result)
                begin
                    $error("power_result: expected %0d, actual %0d (func %0d, base %0d)",
                           entry.power_result, rsp_if.power_result,
                           entry.func, entry.base_value);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog. Any accepted item on any channel restarts the count; a long
    // run of cycles with nothing moving means the block has hung.
    always @(posedge clk)
    begin
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
            || (cfg_if.valid && cfg_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no item moved for %0d cycles, %0d results outstanding.",
                     WATCHDOG_LIMIT, expected_powers.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule

// ----- files.f -----
src/mexp_pkg.sv
src/mexp_if.sv
src/mexp_dp.sv
src/mexp_ctrl.sv
src/modular_exponentiation_unit_top.sv
tb/sv/modular_exponentiation_unit_top_test.sv
